[design/xf2d_pkg.sv]
package xf2d_pkg;

   // fixed field widths
   localparam int COORD_W = 8;
   localparam int HASH_W = 64;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   localparam int TABLE_SIDE_DEFAULT = 256;

   // corner counter: four corners for a toggle, two points for a compare
   localparam int CORNER_W = 2;
   localparam logic [CORNER_W-1:0] CORNER_FIRST = 2'd0;
   localparam logic [CORNER_W-1:0] CORNER_SECOND = 2'd1;
   localparam logic [CORNER_W-1:0] CORNER_THIRD = 2'd2;
   localparam logic [CORNER_W-1:0] LAST_TOGGLE_CORNER = 2'd3;
   localparam logic [CORNER_W-1:0] LAST_QUERY_CORNER = 2'd1;

   // action codes carried in tuser
   localparam logic ACT_TOGGLE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH_MUL,
      ST_HASH_SUM,
      ST_CORNER,
      ST_ROW,
      ST_COL,
      ST_DATA
   } ctrl_state_type;

   typedef struct packed {
      logic                take_item;
      logic                hash_mul;
      logic                hash_sum;
      logic                corner_load;
      logic [CORNER_W-1:0] corner_sel;
      logic                row_step;
      logic                col_step;
      logic                mem_read;
      logic                mem_rmw;
      logic                clr_step;
      logic                save_first;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic row_live;
      logic col_live;
      logic in_range;
      logic clr_done;
      logic rsp_full;
   } status_type;

endpackage

[design/xf2d_ctrl.sv]
module xf2d_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_action,
   output logic                 req_tready,
   input  xf2d_pkg::status_type status,
   output xf2d_pkg::cmd_type    cmd
);

   xf2d_pkg::ctrl_state_type          state_ff, state_in;
   logic [xf2d_pkg::CORNER_W-1:0]     corner_ff, corner_in;
   logic [xf2d_pkg::CORNER_W-1:0]     last_corner;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= xf2d_pkg::ST_CLEAR;
         corner_ff <= xf2d_pkg::CORNER_FIRST;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
      end
   end

   assign last_corner = status.is_query ? xf2d_pkg::LAST_QUERY_CORNER
                                        : xf2d_pkg::LAST_TOGGLE_CORNER;

   always_comb begin
      state_in       = state_ff;
      corner_in      = corner_ff;
      req_tready     = 1'b0;
      cmd            = '0;
      cmd.corner_sel = corner_ff;
      case (state_ff)
         xf2d_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_done) begin
               state_in = xf2d_pkg::ST_IDLE;
            end
         end
         xf2d_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            corner_in  = xf2d_pkg::CORNER_FIRST;
            if (req_tvalid) begin
               cmd.take_item = 1'b1;
               if (req_action == xf2d_pkg::ACT_QUERY) begin
                  state_in = xf2d_pkg::ST_CORNER;
               end else begin
                  state_in = xf2d_pkg::ST_HASH_MUL;
               end
            end
         end
         xf2d_pkg::ST_HASH_MUL: begin
            cmd.hash_mul = 1'b1;
            state_in     = xf2d_pkg::ST_HASH_SUM;
         end
         xf2d_pkg::ST_HASH_SUM: begin
            cmd.hash_sum = 1'b1;
            state_in     = xf2d_pkg::ST_CORNER;
         end
         xf2d_pkg::ST_CORNER: begin
            cmd.corner_load = 1'b1;
            state_in        = xf2d_pkg::ST_ROW;
         end
         xf2d_pkg::ST_ROW: begin
            if (status.row_live) begin
               state_in = xf2d_pkg::ST_COL;
            end else if (corner_ff == last_corner) begin
               if (!status.is_query) begin
                  state_in = xf2d_pkg::ST_IDLE;
               end else if (!status.rsp_full) begin
                  // hold here until the output register is free
                  cmd.rsp_load = 1'b1;
                  state_in     = xf2d_pkg::ST_IDLE;
               end
            end else begin
               cmd.save_first = status.is_query;
               corner_in      = corner_ff + 1'b1;
               state_in       = xf2d_pkg::ST_CORNER;
            end
         end
         xf2d_pkg::ST_COL: begin
            if (!status.col_live) begin
               cmd.row_step = 1'b1;
               state_in     = xf2d_pkg::ST_ROW;
            end else if (status.in_range) begin
               cmd.mem_read = 1'b1;
               state_in     = xf2d_pkg::ST_DATA;
            end else begin
               cmd.col_step = 1'b1;
            end
         end
         xf2d_pkg::ST_DATA: begin
            cmd.mem_rmw  = 1'b1;
            cmd.col_step = 1'b1;
            state_in     = xf2d_pkg::ST_COL;
         end
         default: begin
            state_in = xf2d_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[design/xf2d_datapath.sv]
module xf2d_datapath #(
   parameter int TABLE_SIDE = xf2d_pkg::TABLE_SIDE_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [xf2d_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_action,
   input  xf2d_pkg::cmd_type                 cmd,
   output xf2d_pkg::status_type              status,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [xf2d_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int AW = $clog2(TABLE_SIDE);
   localparam int CW = (AW + 1 > xf2d_pkg::COORD_W + 1) ? AW + 1 : xf2d_pkg::COORD_W + 1;
   localparam int MW = 2 * AW;
   localparam int HW = xf2d_pkg::HASH_W;
   localparam int XW = xf2d_pkg::COORD_W;
   localparam logic [CW-1:0] SIDE = CW'(TABLE_SIDE);

   // latched item
   logic [XW-1:0] r1_ff, c1_ff, r2_ff, c2_ff;
   logic          query_ff;

   // hash pipeline
   logic [2*XW:0]   prod_a_ff;
   logic [2*XW+1:0] prod_b_ff;
   logic [HW-1:0]   shift_a_ff, shift_b_ff, hash_ff;
   logic [XW:0]     sum_rc;
   logic [HW-1:0]   hash_base;

   // walk registers
   logic [CW-1:0] row_ff, col_ff, col_base_ff;
   logic [CW-1:0] corner_row, corner_col;
   logic [CW-1:0] r1_w, c1_w, r2_w, c2_w, r2p_w, c2p_w;
   logic [HW-1:0] acc_ff, first_ff;

   // table memory and clear sweep
   logic [HW-1:0] mem [0:(2**MW)-1];
   logic [HW-1:0] rd_data_ff;
   logic [MW-1:0] clr_addr_ff;
   logic [MW-1:0] walk_addr, wr_addr;
   logic [HW-1:0] wr_data;
   logic          wr_en;

   logic          rsp_valid_ff;
   logic          rsp_same_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         r1_ff    <= req_tdata[XW-1:0];
         c1_ff    <= req_tdata[2*XW-1:XW];
         r2_ff    <= req_tdata[3*XW-1:2*XW];
         c2_ff    <= req_tdata[4*XW-1:3*XW];
         query_ff <= req_action;
      end
   end

   // hash: two small products and two shifts, registered, then a registered sum of all terms
   assign sum_rc    = {1'b0, r1_ff} + {1'b0, c1_ff};
   assign hash_base = {8'd0, r1_ff, 4'd0, r2_ff, 4'd0, c1_ff, 4'd0, c2_ff, 12'd0};

   always_ff @(posedge clock) begin
      if (cmd.hash_mul) begin
         prod_a_ff  <= (2*XW+1)'(r1_ff) * (2*XW+1)'({1'b0, r2_ff} + {1'b0, c2_ff});
         prod_b_ff  <= (2*XW+2)'({1'b0, sum_rc} + {2'b0, c2_ff}) * (2*XW+2)'(r2_ff);
         shift_a_ff <= HW'(sum_rc) << c1_ff[5:0];
         shift_b_ff <= HW'(sum_rc) << c2_ff[5:0];
      end
      if (cmd.hash_sum) begin
         hash_ff <= hash_base + HW'(prod_a_ff) + HW'(prod_b_ff) + shift_a_ff + shift_b_ff;
      end
   end

   // corner selection
   assign r1_w  = CW'(r1_ff);
   assign c1_w  = CW'(c1_ff);
   assign r2_w  = CW'(r2_ff);
   assign c2_w  = CW'(c2_ff);
   assign r2p_w = CW'({1'b0, r2_ff} + 9'd1);
   assign c2p_w = CW'({1'b0, c2_ff} + 9'd1);

   always_comb begin
      corner_row = r1_w;
      corner_col = c1_w;
      if (query_ff) begin
         if (cmd.corner_sel == xf2d_pkg::CORNER_FIRST) begin
            corner_row = r1_w;
            corner_col = c1_w;
         end else begin
            corner_row = r2_w;
            corner_col = c2_w;
         end
      end else begin
         case (cmd.corner_sel)
            xf2d_pkg::CORNER_FIRST: begin
               corner_row = r2p_w;
               corner_col = c2p_w;
            end
            xf2d_pkg::CORNER_SECOND: begin
               corner_row = r2p_w;
               corner_col = c1_w;
            end
            xf2d_pkg::CORNER_THIRD: begin
               corner_row = r1_w;
               corner_col = c2p_w;
            end
            default: begin
               corner_row = r1_w;
               corner_col = c1_w;
            end
         endcase
      end
   end

   // update walks climb by the low bit, prefix walks drop it
   always_ff @(posedge clock) begin
      if (cmd.corner_load) begin
         row_ff      <= corner_row;
         col_ff      <= corner_col;
         col_base_ff <= corner_col;
         acc_ff      <= '0;
      end else begin
         if (cmd.row_step) begin
            row_ff <= query_ff ? (row_ff & (row_ff - 1'b1)) : (row_ff + (row_ff & (-row_ff)));
            col_ff <= col_base_ff;
         end else if (cmd.col_step) begin
            col_ff <= query_ff ? (col_ff & (col_ff - 1'b1)) : (col_ff + (col_ff & (-col_ff)));
         end
         if (cmd.mem_rmw && query_ff) begin
            acc_ff <= acc_ff ^ rd_data_ff;
         end
      end
      if (cmd.save_first) begin
         first_ff <= acc_ff;
      end
   end

   assign status.is_query = query_ff;
   assign status.row_live = query_ff ? (row_ff != '0)
                                     : (row_ff != '0 && col_base_ff != '0 && row_ff < SIDE);
   assign status.col_live = query_ff ? (col_ff != '0) : (col_ff < SIDE);
   assign status.in_range = (row_ff < SIDE) && (col_ff < SIDE);
   assign status.clr_done = &clr_addr_ff;
   assign status.rsp_full = rsp_valid_ff;

   // table memory, read data registered
   assign walk_addr = {row_ff[AW-1:0], col_ff[AW-1:0]};
   assign wr_en     = cmd.clr_step || (cmd.mem_rmw && !query_ff);
   assign wr_addr   = cmd.clr_step ? clr_addr_ff : walk_addr;
   assign wr_data   = cmd.clr_step ? '0 : (rd_data_ff ^ hash_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= mem[walk_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_same_ff <= (first_ff == acc_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(xf2d_pkg::RSP_DATA_W-1){1'b0}}, rsp_same_ff};

endmodule

[design/xor_fenwick_2d_rect_toggle.sv]
// Two-dimensional XOR binary indexed tree of 64-bit words, TABLE_SIDE by TABLE_SIDE,
// held in one single-port-style table memory. A toggle transaction (tuser = 0) hashes
// its rectangle corners and XORs the hash into the four corner points with Fenwick
// update walks; it produces no response. A compare transaction (tuser = 1) takes the
// XOR prefix value at two points and returns one response whose bit 0 is 1 when they
// match. After reset the table is swept to zero, one entry per cycle, over all
// 2**(2*ceil(log2(TABLE_SIDE))) entries (65536 at the default), while req_tready
// stays low. One transaction is worked at a time, and the memory port sets the pace:
// each table entry visited is a registered read, then a write or accumulate; each
// new row of a walk passes through ST_ROW, each corner through ST_CORNER, and a
// toggle first computes its hash. A finished compare result waits in an output
// register, so the next transaction is taken while it is still pending.
module xor_fenwick_2d_rect_toggle #(
   parameter int TABLE_SIDE = xf2d_pkg::TABLE_SIDE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // row_first [7:0], col_first [15:8], row_second [23:16], col_second [31:24]
   input  logic [xf2d_pkg::REQ_DATA_W-1:0] req_tdata,
   // action [0]: 0 toggle rectangle, 1 compare two points
   input  logic                            req_tuser,
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // same_region [0], zero fill above
   output logic [xf2d_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   xf2d_pkg::cmd_type    cmd;
   xf2d_pkg::status_type status;

   // sequencer: clear sweep, hash, corner and walk steps
   xf2d_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_action (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // item registers, hash, walk indexes, table memory and output register
   xf2d_datapath #(
      .TABLE_SIDE (TABLE_SIDE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_action (req_tuser),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // a new result never lands on one still waiting
   assert property (@(posedge clock) disable iff (reset) cmd.rsp_load |-> !rsp_tvalid)
      else $error("response loaded over a pending response");

   // no table access while the block is open for a new transaction
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !cmd.mem_read && !cmd.mem_rmw && !cmd.clr_step)
      else $error("table access while idle");

   // every table read is followed by its write-back or accumulate
   assert property (@(posedge clock) disable iff (reset) cmd.mem_read |=> cmd.mem_rmw)
      else $error("table read without a following update");

   // a loaded response shows on the port in the next cycle
   assert property (@(posedge clock) disable iff (reset) cmd.rsp_load |=> rsp_tvalid)
      else $error("loaded response not presented");

endmodule
